FILE: rtl/rgbup_pkg.sv
package rgbup_pkg;

  localparam int IDX_W   = 26;
  localparam int LEFT_W  = 10;
  localparam int TOP_W   = 10;
  localparam int SIDE_W  = 11;
  localparam int SCALE_W = 4;
  localparam int STRIDE_W = 14;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [15:0] RED_MASK   = 16'hF800;
  localparam logic [15:0] GREEN_MASK = 16'h07E0;
  localparam logic [15:0] BLUE_MASK  = 16'h001F;

  typedef enum logic [2:0] {
    REG_LEFT   = 3'd0,
    REG_TOP    = 3'd1,
    REG_WIDTH  = 3'd2,
    REG_HEIGHT = 3'd3,
    REG_SCALE  = 3'd4,
    REG_STRIDE = 3'd5
  } rgbup_reg_t;

  typedef struct packed {
    logic [LEFT_W-1:0]   left;
    logic [TOP_W-1:0]    top;
    logic [SIDE_W-1:0]   width;
    logic [SIDE_W-1:0]   height;
    logic [SCALE_W-1:0]  scale;
    logic [STRIDE_W-1:0] stride;
  } rgbup_cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] col_base;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic             region_end;
  } rgbup_entry_t;

endpackage

FILE: rtl/rgbup_front.sv
module rgbup_front #(
  parameter int MAX_REGION_SIDE = 1024,
  parameter int MAX_SCALE = 8,
  parameter int CW = $clog2(MAX_REGION_SIDE),
  parameter int SW = $clog2(MAX_REGION_SIDE + 1),
  parameter int SC_W = $clog2(MAX_SCALE + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                restart,
  input  rgbup_pkg::rgbup_cfg_t cfg,
  input  logic [SC_W-1:0]     s_eff,
  input  logic [SW-1:0]       w_eff,
  input  logic [SW-1:0]       h_eff,
  input  logic                in_valid,
  input  logic [15:0]         in_pixel_565,
  output logic                in_stall,
  input  logic                q_full,
  output logic                q_push,
  output rgbup_pkg::rgbup_entry_t q_data
);
  import rgbup_pkg::*;

  localparam int TS_W = TOP_W + SC_W;
  localparam int LS_W = LEFT_W + SC_W;

  logic [CW-1:0]    col_cnt_r, col_cnt_nxt;
  logic [CW-1:0]    row_cnt_r, row_cnt_nxt;
  logic [IDX_W-1:0] row_base_r, row_base_nxt;
  logic [IDX_W-1:0] col_base_r, col_base_nxt;
  logic [1:0]       prep_r, prep_nxt;
  logic [TS_W-1:0]  top_s_r;
  logic [LS_W-1:0]  left_s_r;
  logic [IDX_W-1:0] row_step_r;
  logic [IDX_W-1:0] origin_r, origin_nxt;
  logic             accept, last_col, last_row;

  // The origin is built over two register stages, so the input is held off
  // after reset and after every register write while the origin is rebuilt.
  assign origin_nxt = IDX_W'(32'(top_s_r) * 32'(cfg.stride) + 32'(left_s_r));

  always_ff @(posedge clk) begin
    top_s_r    <= TS_W'(32'(cfg.top) * 32'(s_eff));
    left_s_r   <= LS_W'(32'(cfg.left) * 32'(s_eff));
    row_step_r <= IDX_W'(32'(s_eff) * 32'(cfg.stride));
    origin_r   <= origin_nxt;
  end

  assign in_stall = (prep_r != 2'd0) || q_full;
  assign accept   = in_valid && !in_stall;
  assign last_col = (32'(col_cnt_r) + 32'd1) >= 32'(w_eff);
  assign last_row = (32'(row_cnt_r) + 32'd1) >= 32'(h_eff);

  assign q_push              = accept;
  assign q_data.col_base     = col_base_r;
  assign q_data.red          = 8'(((in_pixel_565 & RED_MASK) >> 11) << 3);
  assign q_data.green        = 8'(((in_pixel_565 & GREEN_MASK) >> 5) << 2);
  assign q_data.blue         = 8'((in_pixel_565 & BLUE_MASK) << 3);
  assign q_data.region_end   = last_col && last_row;

  always_comb begin
    col_cnt_nxt  = col_cnt_r;
    row_cnt_nxt  = row_cnt_r;
    row_base_nxt = row_base_r;
    col_base_nxt = col_base_r;
    prep_nxt     = prep_r;
    if (restart) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = '0;
      prep_nxt    = 2'd2;
    end else if (prep_r != 2'd0) begin
      prep_nxt = prep_r - 2'd1;
      if (prep_r == 2'd1) begin
        row_base_nxt = origin_nxt;
        col_base_nxt = origin_nxt;
      end
    end else if (accept) begin
      if (!last_col) begin
        col_cnt_nxt  = col_cnt_r + CW'(1);
        col_base_nxt = col_base_r + IDX_W'(s_eff);
      end else if (!last_row) begin
        col_cnt_nxt  = '0;
        row_cnt_nxt  = row_cnt_r + CW'(1);
        row_base_nxt = row_base_r + row_step_r;
        col_base_nxt = row_base_r + row_step_r;
      end else begin
        col_cnt_nxt  = '0;
        row_cnt_nxt  = '0;
        row_base_nxt = origin_r;
        col_base_nxt = origin_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      prep_r    <= 2'd2;
    end else begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
      prep_r    <= prep_nxt;
    end
    row_base_r <= row_base_nxt;
    col_base_r <= col_base_nxt;
  end

endmodule

FILE: rtl/rgbup_fifo.sv
module rgbup_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  rgbup_pkg::rgbup_entry_t push_data,
  output logic                    full,
  input  logic                    pop,
  output logic                    not_empty,
  output rgbup_pkg::rgbup_entry_t pop_data
);
  import rgbup_pkg::*;

  rgbup_entry_t      mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = cnt_r == QCNT_W'(QDEPTH);
  assign not_empty = cnt_r != '0;
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/rgbup_back.sv
module rgbup_back #(
  parameter int MAX_SCALE = 8,
  parameter int SC_W = $clog2(MAX_SCALE + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [SC_W-1:0]         s_eff,
  input  logic [rgbup_pkg::STRIDE_W-1:0] stride,
  input  logic                    q_not_empty,
  input  rgbup_pkg::rgbup_entry_t q_data,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [rgbup_pkg::IDX_W-1:0] out_target_index,
  output logic [7:0]              out_red,
  output logic [7:0]              out_green,
  output logic [7:0]              out_blue,
  output logic                    out_last_replica,
  output logic                    out_region_done
);
  import rgbup_pkg::*;

  rgbup_entry_t     ent_r, ent_nxt;
  logic             busy_r, busy_nxt;
  logic [SC_W-1:0]  dx_r, dx_nxt, dy_r, dy_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt, rowst_r, rowst_nxt;
  logic             ov_r, ov_nxt;
  logic [IDX_W-1:0] o_idx_r;
  logic [7:0]       o_red_r, o_green_r, o_blue_r;
  logic             o_last_r, o_done_r;
  logic             emit, dx_last, dy_last, fin;

  // A replica moves into the output register whenever it is empty or is being
  // taken in the same cycle, so a pixel's replicas leave back to back.
  assign emit    = busy_r && (!ov_r || !out_stall);
  assign dx_last = (32'(dx_r) + 32'd1) == 32'(s_eff);
  assign dy_last = (32'(dy_r) + 32'd1) == 32'(s_eff);
  assign fin     = dx_last && dy_last;
  assign q_pop   = q_not_empty && (!busy_r || (emit && fin));

  always_comb begin
    ent_nxt   = ent_r;
    busy_nxt  = busy_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    idx_nxt   = idx_r;
    rowst_nxt = rowst_r;
    if (q_pop) begin
      ent_nxt   = q_data;
      busy_nxt  = 1'b1;
      dx_nxt    = '0;
      dy_nxt    = '0;
      idx_nxt   = q_data.col_base;
      rowst_nxt = q_data.col_base;
    end else if (emit && fin) begin
      busy_nxt = 1'b0;
    end else if (emit) begin
      if (dx_last) begin
        dx_nxt    = '0;
        dy_nxt    = dy_r + SC_W'(1);
        rowst_nxt = rowst_r + IDX_W'(stride);
        idx_nxt   = rowst_r + IDX_W'(stride);
      end else begin
        dx_nxt  = dx_r + SC_W'(1);
        idx_nxt = idx_r + IDX_W'(1);
      end
    end
  end

  always_comb begin
    ov_nxt = ov_r;
    if (emit) begin
      ov_nxt = 1'b1;
    end else if (!out_stall) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
    ent_r   <= ent_nxt;
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    idx_r   <= idx_nxt;
    rowst_r <= rowst_nxt;
    if (emit) begin
      o_idx_r   <= idx_r;
      o_red_r   <= ent_r.red;
      o_green_r <= ent_r.green;
      o_blue_r  <= ent_r.blue;
      o_last_r  <= fin;
      o_done_r  <= fin && ent_r.region_end;
    end
  end

  assign out_valid        = ov_r;
  assign out_target_index = o_idx_r;
  assign out_red          = o_red_r;
  assign out_green        = o_green_r;
  assign out_blue         = o_blue_r;
  assign out_last_replica = o_last_r;
  assign out_region_done  = o_done_r;

endmodule

FILE: rtl/rgb565_region_upscaler_unit.sv
// A pixel passes through the queue and the entry and output registers. Each
// source pixel gives scale*scale replicas, one per cycle from the back end unless
// the output stalls; a four-entry queue lets the front take pixels while replicas
// drain. Reset (synchronous, active low) and every register write restart the
// region at its first pixel and stall the input while the origin is rebuilt.
module rgb565_region_upscaler_unit #(
  parameter int MAX_REGION_SIDE = 1024,
  parameter int MAX_SCALE = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_pixel_565,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [rgbup_pkg::IDX_W-1:0] out_target_index,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_last_replica,
  output logic        out_region_done,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [rgbup_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [rgbup_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [rgbup_pkg::DATA_W-1:0] cfg_prdata,
  output logic        cfg_pready
);
  import rgbup_pkg::*;

  localparam int CW   = $clog2(MAX_REGION_SIDE);
  localparam int SW   = $clog2(MAX_REGION_SIDE + 1);
  localparam int SC_W = $clog2(MAX_SCALE + 1);

  rgbup_cfg_t   cfg_r, cfg_nxt;
  logic         wr_en, restart;
  logic [2:0]   reg_sel;
  logic [SC_W-1:0] s_eff;
  logic [SW-1:0]   w_eff, h_eff;
  logic         q_push, q_full, q_pop, q_not_empty;
  rgbup_entry_t q_wdata, q_rdata;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_sel    = cfg_paddr[4:2];

  always_comb begin
    cfg_nxt = cfg_r;
    restart = 1'b0;
    if (wr_en) begin
      restart = 1'b1;
      case (reg_sel)
        REG_LEFT:   cfg_nxt.left   = cfg_pwdata[LEFT_W-1:0];
        REG_TOP:    cfg_nxt.top    = cfg_pwdata[TOP_W-1:0];
        REG_WIDTH:  cfg_nxt.width  = cfg_pwdata[SIDE_W-1:0];
        REG_HEIGHT: cfg_nxt.height = cfg_pwdata[SIDE_W-1:0];
        REG_SCALE:  cfg_nxt.scale  = cfg_pwdata[SCALE_W-1:0];
        REG_STRIDE: cfg_nxt.stride = cfg_pwdata[STRIDE_W-1:0];
        default:    restart = 1'b0;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_LEFT:   cfg_prdata = DATA_W'(cfg_r.left);
      REG_TOP:    cfg_prdata = DATA_W'(cfg_r.top);
      REG_WIDTH:  cfg_prdata = DATA_W'(cfg_r.width);
      REG_HEIGHT: cfg_prdata = DATA_W'(cfg_r.height);
      REG_SCALE:  cfg_prdata = DATA_W'(cfg_r.scale);
      REG_STRIDE: cfg_prdata = DATA_W'(cfg_r.stride);
      default:    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.left   <= '0;
      cfg_r.top    <= '0;
      cfg_r.width  <= SIDE_W'(1);
      cfg_r.height <= SIDE_W'(1);
      cfg_r.scale  <= SCALE_W'(2);
      cfg_r.stride <= STRIDE_W'(2048);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Zero is taken as one and anything past the maximum saturates.
  always_comb begin
    if (cfg_r.scale == '0) begin
      s_eff = SC_W'(1);
    end else if (32'(cfg_r.scale) > 32'(MAX_SCALE)) begin
      s_eff = SC_W'(MAX_SCALE);
    end else begin
      s_eff = SC_W'(cfg_r.scale);
    end
    if (cfg_r.width == '0) begin
      w_eff = SW'(1);
    end else if (32'(cfg_r.width) > 32'(MAX_REGION_SIDE)) begin
      w_eff = SW'(MAX_REGION_SIDE);
    end else begin
      w_eff = SW'(cfg_r.width);
    end
    if (cfg_r.height == '0) begin
      h_eff = SW'(1);
    end else if (32'(cfg_r.height) > 32'(MAX_REGION_SIDE)) begin
      h_eff = SW'(MAX_REGION_SIDE);
    end else begin
      h_eff = SW'(cfg_r.height);
    end
  end

  rgbup_front #(
    .MAX_REGION_SIDE(MAX_REGION_SIDE),
    .MAX_SCALE(MAX_SCALE),
    .CW(CW),
    .SW(SW),
    .SC_W(SC_W)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .restart(restart),
    .cfg(cfg_r),
    .s_eff(s_eff),
    .w_eff(w_eff),
    .h_eff(h_eff),
    .in_valid(in_valid),
    .in_pixel_565(in_pixel_565),
    .in_stall(in_stall),
    .q_full(q_full),
    .q_push(q_push),
    .q_data(q_wdata)
  );

  rgbup_fifo u_fifo (
    .clk(clk),
    .rst_n(rst_n),
    .push(q_push),
    .push_data(q_wdata),
    .full(q_full),
    .pop(q_pop),
    .not_empty(q_not_empty),
    .pop_data(q_rdata)
  );

  rgbup_back #(
    .MAX_SCALE(MAX_SCALE),
    .SC_W(SC_W)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .s_eff(s_eff),
    .stride(cfg_r.stride),
    .q_not_empty(q_not_empty),
    .q_data(q_rdata),
    .q_pop(q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_target_index(out_target_index),
    .out_red(out_red),
    .out_green(out_green),
    .out_blue(out_blue),
    .out_last_replica(out_last_replica),
    .out_region_done(out_region_done)
  );

endmodule

FILE: rtl/rgbup_checker.sv
module rgbup_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [rgbup_pkg::IDX_W-1:0] out_target_index,
  input logic [7:0]  out_red,
  input logic [7:0]  out_green,
  input logic [7:0]  out_blue,
  input logic        out_last_replica,
  input logic        out_region_done,
  input logic        cfg_psel,
  input logic        cfg_penable,
  input logic        cfg_pwrite,
  input logic [rgbup_pkg::ADDR_W-1:0] cfg_paddr,
  input logic        cfg_pready
);
  import rgbup_pkg::*;

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_target_index)
      && $stable(out_red) && $stable(out_green) && $stable(out_blue)
      && $stable(out_last_replica) && $stable(out_region_done))
    else $error("stalled result changed");

  // The region ends only on a pixel's final replica.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_region_done |-> out_last_replica)
    else $error("region end outside a final replica");

  // Replicas of one pixel follow each other without a gap.
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_replica |=> out_valid)
    else $error("gap inside a pixel's replicas");

  // The input is held off while the origin is rebuilt after reset.
  a_reset_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input taken right after reset");

  // A register write restarts the region and stalls the input.
  a_write_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
      && (cfg_paddr[4:2] <= REG_STRIDE) |=> in_stall)
    else $error("input taken right after a register write");

endmodule

bind rgb565_region_upscaler_unit rgbup_checker u_rgbup_checker (.*);
